@@ src/gchg_pkg.sv @@
`timescale 1ns / 1ps
package gchg_pkg;

  // Arctangent table for the CORDIC stages, Q30 radians.
  localparam int AtanLen = 24;
  localparam logic [31:0] ATAN_Q30 [AtanLen] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128};

  localparam logic signed [34:0] PiQ30     = 35'sd3373259426;
  localparam logic signed [34:0] HalfPiQ30 = 35'sd1686629713;
  localparam logic signed [34:0] GainQ30   = 35'sd652032874;

  // Configuration register indexes.
  localparam logic [1:0] RegIdleLimit = 2'd0;
  localparam logic [1:0] RegWalkLimit = 2'd1;
  localparam logic [1:0] RegFaceLead  = 2'd2;

  // Gait mode codes.
  localparam logic [1:0] ModeIdle = 2'd0;
  localparam logic [1:0] ModeSlow = 2'd1;
  localparam logic [1:0] ModeWalk = 2'd2;

  // One stage of arctangent lookup, zero past the table.
  function automatic logic signed [34:0] atan_at(input int i);
    logic signed [34:0] r;
    r = '0;
    if (i < AtanLen) r = $signed({3'b000, ATAN_Q30[i]});
    return r;
  endfunction

endpackage

@@ src/gait_command_heading_generator_unit.sv @@
`timescale 1ns / 1ps
// Channel     | Ports                                          | Direction
// command     | start, busy(out), cmd_*, quat_*, plan_empty_i, | in
//             | heading_ref_i, yaw_at_plan_i                   |
// result      | done_o, gait_mode_o, target_speed_o, move_*,   | out
//             | face_*                                         |
// config      | cfg_we_i, cfg_idx_i, cfg_data_i                | in
//
// One transaction enters every cycle; busy is always low. At most 24 stages
// are used in each of the three CORDIC rows. An item passes the quaternion
// product, yaw atan2 row, rounding, heading, course atan2 row, course sum,
// two angle reduction, rotation setup, rotation row and output registers
// before done_o rises.
// Reset clears the valid bits and loads the register defaults.
// The receiver cannot stall, so the pipeline never stops.
module gait_command_heading_generator_unit
  import gchg_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 12,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic signed [15:0]  cmd_forward_i,
  input  logic signed [15:0]  cmd_lateral_i,
  input  logic signed [15:0]  cmd_turn_rate_i,
  input  logic signed [15:0]  quat_w_i,
  input  logic signed [15:0]  quat_x_i,
  input  logic signed [15:0]  quat_y_i,
  input  logic signed [15:0]  quat_z_i,
  input  logic                plan_empty_i,
  input  logic signed [14:0]  heading_ref_i,
  input  logic signed [14:0]  yaw_at_plan_i,
  output logic                done_o,
  output logic [1:0]          gait_mode_o,
  output logic [15:0]         target_speed_o,
  output logic signed [15:0]  move_x_o,
  output logic signed [15:0]  move_y_o,
  output logic signed [15:0]  face_x_o,
  output logic signed [15:0]  face_y_o
);

  localparam int NS   = (CORDIC_STAGES < AtanLen) ? CORDIC_STAGES : AtanLen;
  localparam int SH   = 30 - ANGLE_FRAC_BITS;
  // Wide signed angle/vector datapath.
  localparam int W    = 48;
  // Pipeline layout.
  localparam int LA   = 2 + NS + 1;        // after yaw atan2 and rounding
  localparam int LH   = LA + 1;            // heading formed
  localparam int LC   = LH + NS + 1;       // course angle rounded and summed
  localparam int LT   = LC + 3 + NS;       // sincos done
  localparam int NT   = 17;                // square root steps
  localparam int SD   = LT - NT - 2;       // speed delay length

  typedef logic signed [W-1:0] w_t;

  function automatic w_t rsh(input w_t v);
    return (v + (w_t'(1) <<< (SH - 1))) >>> SH;
  endfunction

  localparam w_t PiA   = (w_t'(PiQ30) + (w_t'(1) <<< (SH - 1))) >>> SH;
  localparam w_t TwoPi = 2 * PiA;

  typedef struct packed {
    logic [15:0] fwd;
    logic [15:0] lat;
    logic [15:0] turn;
    logic        first;
    logic [14:0] href;
    logic [14:0] y0;
  } side_t;

  assign busy = 1'b0;

  // Configuration registers.
  logic [15:0] idle_q, walk_q;
  logic [13:0] lead_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q <= 16'd492;
      walk_q <= 16'd3277;
      lead_q <= 14'd2458;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegIdleLimit: idle_q <= cfg_data_i;
        RegWalkLimit: walk_q <= cfg_data_i;
        RegFaceLead:  lead_q <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  // Valid bits travel with the item along the whole depth.
  logic [LT:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LT-1:0], start};
    end
  end

  // Side-band pipeline carrying the raw item along the whole depth.
  side_t side_q [LT+1];
  always_ff @(posedge clk_i) begin
    side_q[0].fwd <= cmd_forward_i;
    side_q[0].lat <= cmd_lateral_i;
    side_q[0].turn <= cmd_turn_rate_i;
    side_q[0].first <= plan_empty_i;
    side_q[0].href <= heading_ref_i;
    side_q[0].y0 <= yaw_at_plan_i;
    for (int i = 1; i <= LT; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // Vectoring CORDIC, pre-rotation into the right half plane.
  function automatic void vec_pre(input w_t x, input w_t y,
                                  output w_t xo, output w_t yo, output w_t zo,
                                  output logic zf);
    zf = (x == 0) && (y == 0);
    zo = '0; xo = x; yo = y;
    if (x < 0) begin
      zo = (y >= 0) ? w_t'(PiQ30) : -w_t'(PiQ30);
      xo = -x; yo = -y;
    end
  endfunction

  // Quaternion products in stage 0; sums and pre-rotation feed stage 1.
  logic signed [31:0] p_wz_q, p_xy_q, p_yy_q, p_zz_q;
  w_t qy_d, qx_d, ax_d, ay_d, az_d;
  logic azf_d;
  always_ff @(posedge clk_i) begin
    p_wz_q <= quat_w_i * quat_z_i;
    p_xy_q <= quat_x_i * quat_y_i;
    p_yy_q <= quat_y_i * quat_y_i;
    p_zz_q <= quat_z_i * quat_z_i;
  end
  always_comb begin
    qy_d = 2 * (w_t'(p_wz_q) + w_t'(p_xy_q));
    qx_d = (w_t'(1) <<< 28) - 2 * (w_t'(p_yy_q) + w_t'(p_zz_q));
    vec_pre(qx_d, qy_d, ax_d, ay_d, az_d, azf_d);
  end

  // Yaw atan2 rows.
  w_t ax_q [NS+1], ay_q [NS+1], az_q [NS+1];
  logic azf_q [NS+1];
  always_ff @(posedge clk_i) begin
    ax_q[0] <= ax_d;
    ay_q[0] <= ay_d;
    az_q[0] <= az_d;
    azf_q[0] <= azf_d;
    for (int i = 0; i < NS; i++) begin
      azf_q[i+1] <= azf_q[i];
      if (ay_q[i] >= 0) begin
        ax_q[i+1] <= ax_q[i] + (ay_q[i] >>> i);
        ay_q[i+1] <= ay_q[i] - (ax_q[i] >>> i);
        az_q[i+1] <= az_q[i] + w_t'(atan_at(i));
      end else begin
        ax_q[i+1] <= ax_q[i] - (ay_q[i] >>> i);
        ay_q[i+1] <= ay_q[i] + (ax_q[i] >>> i);
        az_q[i+1] <= az_q[i] - w_t'(atan_at(i));
      end
    end
  end

  // Rounded yaw.
  w_t here_q;
  always_ff @(posedge clk_i) here_q <= azf_q[NS] ? '0 : rsh(az_q[NS]);

  // Heading: wrap the offset once each way.
  w_t psi_q, psi_d;
  always_comb begin
    w_t d;
    d = here_q - w_t'($signed(side_q[LA-1].y0));
    if (d > PiA) d = d - TwoPi;
    if (d < -PiA) d = d + TwoPi;
    psi_d = side_q[LA-1].first ? here_q : w_t'($signed(side_q[LA-1].href)) + d;
  end
  always_ff @(posedge clk_i) psi_q <= psi_d;

  // Heading delay to the sincos input.
  w_t psid_q [LC-LH];
  always_ff @(posedge clk_i) begin
    psid_q[0] <= psi_q;
    for (int i = 1; i < LC - LH; i++) psid_q[i] <= psid_q[i-1];
  end

  // Course atan2 over the command vector, aligned to start with heading.
  w_t cx_d, cy_d, cz_d;
  logic czf_d;
  always_comb begin
    vec_pre(w_t'($signed(side_q[LH-1].fwd)) <<< 16,
            w_t'($signed(side_q[LH-1].lat)) <<< 16,
            cx_d, cy_d, cz_d, czf_d);
  end
  w_t cx_q [NS+1], cy_q [NS+1], cz_q [NS+1];
  logic czf_q [NS+1];
  always_ff @(posedge clk_i) begin
    cx_q[0] <= cx_d;
    cy_q[0] <= cy_d;
    cz_q[0] <= cz_d;
    czf_q[0] <= czf_d;
    for (int i = 0; i < NS; i++) begin
      czf_q[i+1] <= czf_q[i];
      if (cy_q[i] >= 0) begin
        cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
        cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
        cz_q[i+1] <= cz_q[i] + w_t'(atan_at(i));
      end else begin
        cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
        cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
        cz_q[i+1] <= cz_q[i] - w_t'(atan_at(i));
      end
    end
  end

  // Course and facing angles; lead product formed one stage earlier.
  logic signed [31:0] lead_prod_q;
  w_t course_q, faceyaw_q;
  always_ff @(posedge clk_i) begin
    lead_prod_q <= $signed(side_q[LC-2].turn) * $signed({1'b0, lead_q});
    course_q <= psid_q[LC-LH-1] + (czf_q[NS] ? w_t'(0) : rsh(cz_q[NS]));
    faceyaw_q <= psid_q[LC-LH-1] +
      ((w_t'(lead_prod_q) + (w_t'(1) <<< (23 - ANGLE_FRAC_BITS))) >>>
       (24 - ANGLE_FRAC_BITS));
  end

  // Coarse angle reduction: remove four, then two whole turns.
  function automatic w_t red_coarse(input w_t a);
    w_t r;
    r = a;
    if (r > 7 * PiA) r = r - 8 * PiA;
    else if (r < -7 * PiA) r = r + 8 * PiA;
    if (r > 3 * PiA) r = r - 4 * PiA;
    else if (r < -3 * PiA) r = r + 4 * PiA;
    return r;
  endfunction

  // Fine angle reduction into the range (-pi, pi] around zero.
  function automatic w_t red(input w_t a);
    w_t r;
    r = a;
    if (r > PiA) r = r - TwoPi;
    if (r > PiA) r = r - TwoPi;
    if (r <= -PiA) r = r + TwoPi;
    if (r <= -PiA) r = r + TwoPi;
    return r;
  endfunction
  w_t mc_q, fc_q, mr_q, fr_q;
  always_ff @(posedge clk_i) begin
    mc_q <= red_coarse(course_q);
    fc_q <= red_coarse(faceyaw_q);
    mr_q <= red(mc_q);
    fr_q <= red(fc_q);
  end

  // Rotation CORDIC, two lanes.
  w_t rx_q [2][NS+1], ry_q [2][NS+1], rz_q [2][NS+1];
  logic rn_q [2][NS+1];
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      w_t z;
      w_t zr;
      logic n;
      z = (l == 0 ? mr_q : fr_q) <<< SH;
      zr = z;
      n = 1'b0;
      if (z > w_t'(HalfPiQ30)) begin
        zr = z - w_t'(PiQ30); n = 1'b1;
      end else if (z < -w_t'(HalfPiQ30)) begin
        zr = z + w_t'(PiQ30); n = 1'b1;
      end
      rx_q[l][0] <= w_t'(GainQ30);
      ry_q[l][0] <= '0;
      rn_q[l][0] <= n;
      rz_q[l][0] <= zr;
      for (int i = 0; i < NS; i++) begin
        rn_q[l][i+1] <= rn_q[l][i];
        if (rz_q[l][i] >= 0) begin
          rx_q[l][i+1] <= rx_q[l][i] - (ry_q[l][i] >>> i);
          ry_q[l][i+1] <= ry_q[l][i] + (rx_q[l][i] >>> i);
          rz_q[l][i+1] <= rz_q[l][i] - w_t'(atan_at(i));
        end else begin
          rx_q[l][i+1] <= rx_q[l][i] + (ry_q[l][i] >>> i);
          ry_q[l][i+1] <= ry_q[l][i] - (rx_q[l][i] >>> i);
          rz_q[l][i+1] <= rz_q[l][i] + w_t'(atan_at(i));
        end
      end
    end
  end

  function automatic logic signed [15:0] unit_out(input w_t v, input logic n);
    w_t r;
    r = ((n ? -v : v) + w_t'(32768)) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  // Square root of the command speed: one result bit per stage.
  logic [33:0] srem_q [NT];
  logic [31:0] sval_q [NT];
  logic [16:0] sres_q [NT+1];
  always_ff @(posedge clk_i) begin
    sval_q[0] <= 32'($signed(side_q[1].fwd) * $signed(side_q[1].fwd) +
                     $signed(side_q[1].lat) * $signed(side_q[1].lat));
    srem_q[0] <= '0;
    sres_q[0] <= '0;
    for (int i = 0; i < NT - 1; i++) begin
      logic [33:0] t;
      t = {srem_q[i][31:0], sval_q[i][31:30]};
      sval_q[i+1] <= sval_q[i] << 2;
      if (t >= {15'd0, sres_q[i], 2'b01}) begin
        srem_q[i+1] <= t - {15'd0, sres_q[i], 2'b01};
        sres_q[i+1] <= {sres_q[i][15:0], 1'b1};
      end else begin
        srem_q[i+1] <= t;
        sres_q[i+1] <= {sres_q[i][15:0], 1'b0};
      end
    end
    sres_q[NT] <= (srem_q[NT-1] > 34'(sres_q[NT-1])) ? sres_q[NT-1] + 17'd1
                                                      : sres_q[NT-1];
  end

  // Speed delay to the output.
  logic [16:0] spd_q [SD];
  always_ff @(posedge clk_i) begin
    spd_q[0] <= sres_q[NT];
    for (int i = 1; i < SD; i++) spd_q[i] <= spd_q[i-1];
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= vld_q[LT];
  end
  always_ff @(posedge clk_i) begin
    logic stp;
    stp = spd_q[SD-1] > {1'b0, idle_q};
    gait_mode_o <= (!stp || side_q[LT].first) ? ModeIdle :
                   (spd_q[SD-1] < {1'b0, walk_q}) ? ModeSlow : ModeWalk;
    target_speed_o <= (!stp || side_q[LT].first) ? 16'd0 : spd_q[SD-1][15:0];
    move_x_o <= stp ? unit_out(rx_q[0][NS], rn_q[0][NS]) : 16'sd0;
    move_y_o <= stp ? unit_out(ry_q[0][NS], rn_q[0][NS]) : 16'sd0;
    face_x_o <= unit_out(rx_q[1][NS], rn_q[1][NS]);
    face_y_o <= unit_out(ry_q[1][NS], rn_q[1][NS]);
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import gchg_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 200;
  localparam int AngleFrac = 12;
  localparam int Stages = 16;
  localparam longint PiBig = 64'd3373259426;
  localparam longint HalfPiBig = 64'd1686629713;
  localparam longint GainBig = 64'd652032874;
  localparam longint Unit = 64'd16384;
  localparam longint ArcTab [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  typedef struct {
    logic signed [15:0] fwd;
    logic signed [15:0] lat;
    logic signed [15:0] turn;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic               empty;
    logic signed [14:0] href;
    logic signed [14:0] yplan;
  } command_t;

  typedef struct {
    logic [1:0]         mode;
    logic [15:0]        speed;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] fx;
    logic signed [15:0] fy;
  } plan_cmd_t;

  // Directed row: a command and, where obvious, the gait mode and speed.
  typedef struct {
    int         fwd, lat, turn, qw, qx, qy, qz, empty, href, yplan;
    bit         typed;
    logic [1:0] mode;
    int         speed;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = RegIdleLimit;
  logic [15:0] cfg_data_i = '0;
  logic signed [15:0] cmd_forward_i = '0;
  logic signed [15:0] cmd_lateral_i = '0;
  logic signed [15:0] cmd_turn_rate_i = '0;
  logic signed [15:0] quat_w_i = '0;
  logic signed [15:0] quat_x_i = '0;
  logic signed [15:0] quat_y_i = '0;
  logic signed [15:0] quat_z_i = '0;
  logic plan_empty_i = 1'b0;
  logic signed [14:0] heading_ref_i = '0;
  logic signed [14:0] yaw_at_plan_i = '0;
  logic done_o;
  logic [1:0] gait_mode_o;
  logic [15:0] target_speed_o;
  logic signed [15:0] move_x_o, move_y_o, face_x_o, face_y_o;

  // Local copy of the configuration registers.
  longint idle_limit = 492;
  longint walk_limit = 3277;
  longint lead_time = 2458;

  plan_cmd_t pending_cmds[$];
  int errors = 0;
  int cycles = 0;

  gait_command_heading_generator_unit dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint pi_angle();
    return rnd_shift(PiBig, 30 - AngleFrac);
  endfunction

  // Vectoring CORDIC giving the angle of (x, y).
  function automatic longint vec_angle(longint y, longint x);
    longint z, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PiBig : -PiBig;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < Stages && i < 24; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += ArcTab[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= ArcTab[i];
      end
      x = nx;
      y = ny;
    end
    return rnd_shift(z, 30 - AngleFrac);
  endfunction

  function automatic longint clip_unit(longint v);
    if (v > Unit) return Unit;
    if (v < -Unit) return -Unit;
    return v;
  endfunction

  // Rotation CORDIC giving cos and sin in Q14.
  function automatic void unit_dir(input longint a, output longint c, output longint s);
    longint two_pi, r, x, y, z, nx, ny;
    bit neg;
    two_pi = 2 * pi_angle();
    r = a % two_pi;
    x = GainBig;
    y = 0;
    neg = 0;
    if (r > pi_angle()) r -= two_pi;
    if (r <= -pi_angle()) r += two_pi;
    z = r * (longint'(1) << (30 - AngleFrac));
    if (z > HalfPiBig) begin
      z -= PiBig;
      neg = 1;
    end else if (z < -HalfPiBig) begin
      z += PiBig;
      neg = 1;
    end
    for (int i = 0; i < Stages && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= ArcTab[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += ArcTab[i];
      end
      x = nx;
      y = ny;
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    c = clip_unit(rnd_shift(x, 16));
    s = clip_unit(rnd_shift(y, 16));
  endfunction

  function automatic longint root_rounded(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (v > r) r++;
    return r;
  endfunction

  // Computes the planner command expected for one transaction.
  function automatic plan_cmd_t planner_command(command_t c);
    plan_cmd_t p;
    longint fwd, lat, base_yaw, psi, d, speed, mx, my, fx, fy, course;
    bit stepping;
    fwd = c.fwd;
    lat = c.lat;
    mx = 0;
    my = 0;
    base_yaw = vec_angle(2 * (longint'(c.qw) * c.qz + longint'(c.qx) * c.qy),
        (longint'(1) << 28) - 2 * (longint'(c.qy) * c.qy + longint'(c.qz) * c.qz));
    if (c.empty) begin
      psi = base_yaw;
    end else begin
      d = base_yaw - c.yplan;
      while (d > pi_angle()) d -= 2 * pi_angle();
      while (d < -pi_angle()) d += 2 * pi_angle();
      psi = c.href + d;
    end
    speed = root_rounded(fwd * fwd + lat * lat);
    stepping = speed > idle_limit;
    if (!stepping || c.empty) p.mode = ModeIdle;
    else if (speed < walk_limit) p.mode = ModeSlow;
    else p.mode = ModeWalk;
    p.speed = (c.empty || !stepping) ? 16'd0 : speed[15:0];
    if (stepping) begin
      course = psi + vec_angle(lat * 65536, fwd * 65536);
      unit_dir(course, mx, my);
    end
    unit_dir(psi + rnd_shift(longint'(c.turn) * lead_time, 24 - AngleFrac), fx, fy);
    p.mx = mx[15:0];
    p.my = my[15:0];
    p.fx = fx[15:0];
    p.fy = fy[15:0];
    return p;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Sends one transaction after a random gap and queues its expected command.
  task automatic issue(input command_t c, input bit typed, input logic [1:0] mode,
                       input int speed);
    plan_cmd_t p;
    int gap;
    gap = $urandom_range(0, 4);
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_forward_i <= c.fwd;
    cmd_lateral_i <= c.lat;
    cmd_turn_rate_i <= c.turn;
    quat_w_i <= c.qw;
    quat_x_i <= c.qx;
    quat_y_i <= c.qy;
    quat_z_i <= c.qz;
    plan_empty_i <= c.empty;
    heading_ref_i <= c.href;
    yaw_at_plan_i <= c.yplan;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    p = planner_command(c);
    if (typed) begin
      p.mode = mode;
      p.speed = speed[15:0];
    end
    pending_cmds.push_back(p);
  endtask

  // Stops sending and waits until every expected command has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_cmds.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegIdleLimit) idle_limit = data;
    else if (idx == RegWalkLimit) walk_limit = data;
    else if (idx == RegFaceLead) lead_time = data & 16'h3fff;
  endtask

  function automatic int rnd_signed(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // Mostly planned commands with speeds near the limits, some noise.
  function automatic command_t random_command();
    command_t c;
    int lim;
    case ($urandom_range(0, 3))
      0: lim = 600;
      1: lim = 4000;
      2: lim = 12000;
      default: lim = 32767;
    endcase
    c.fwd = 16'(rnd_signed(lim));
    c.lat = ($urandom_range(0, 4) == 0) ? 16'sd0 : 16'(rnd_signed(lim));
    if ($urandom_range(0, 15) == 0) c.fwd = -16'sd32768;
    c.turn = ($urandom_range(0, 1) != 0) ? 16'(rnd_signed(8192)) : 16'($urandom());
    c.qw = 16'(rnd_signed(16384));
    c.qx = ($urandom_range(0, 1) != 0) ? 16'(rnd_signed(16384)) : 16'(rnd_signed(1024));
    c.qy = ($urandom_range(0, 1) != 0) ? 16'(rnd_signed(16384)) : 16'(rnd_signed(1024));
    c.qz = 16'(rnd_signed(16384));
    c.empty = ($urandom_range(0, 7) == 0);
    c.href = 15'(rnd_signed(12868));
    c.yplan = 15'(rnd_signed(12868));
    return c;
  endfunction

  // Directed rows: extremes, plan empty, no stepping, atan2 special cases.
  row_t rows [17] = '{
    '{0, 0, 0, 16384, 0, 0, 0, 1, 0, 0, 1, ModeIdle, 0},
    '{32767, 0, 0, 16384, 0, 0, 0, 1, 0, 0, 1, ModeIdle, 0},
    '{0, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 1, ModeIdle, 0},
    '{32767, 0, 32767, 16384, 0, 0, 0, 0, 12868, -12868, 1, ModeWalk, 32767},
    '{-32768, -32768, -32768, -16384, 0, 0, 0, 0, -12868, 12868, 1, ModeWalk, 46341},
    '{32767, 32767, 0, 0, 0, 0, 16384, 0, 12868, 12868, 1, ModeWalk, 46340},
    '{492, 0, 100, 16384, 0, 0, 0, 0, 0, 0, 1, ModeIdle, 0},
    '{493, 0, 100, 16384, 0, 0, 0, 0, 0, 0, 1, ModeSlow, 493},
    '{3276, 0, -100, 16384, 0, 0, 0, 0, 0, 0, 1, ModeSlow, 3276},
    '{0, -3277, 0, 16384, 0, 0, 0, 0, 0, 0, 1, ModeWalk, 3277},
    '{-2000, 0, 0, 0, 0, 16384, 0, 0, 1000, -1000, 0, ModeIdle, 0},
    '{1000, 0, 0, 0, 0, 8192, 8192, 0, 12868, -12868, 0, ModeIdle, 0},
    '{1000, 1000, 0, 0, 0, 8192, 8192, 1, 0, 0, 0, ModeIdle, 0},
    '{0, 2000, 5000, 1000, 3000, -500, 200, 0, -12868, 12868, 0, ModeIdle, 0},
    '{-1500, -1500, -32768, 11585, 0, 0, -11585, 0, 100, 12000, 0, ModeIdle, 0},
    '{700, -900, 4000, 16384, 16384, 16384, 16384, 0, 0, -5000, 0, ModeIdle, 0},
    '{-700, 900, -4000, -16384, -16384, -16384, -16384, 0, 3000, 0, 0, ModeIdle, 0}
  };

  // Result checker: done_o marks one transaction for exactly one cycle.
  always @(posedge clk_i) begin
    plan_cmd_t want;
    if (rst_ni && done_o) begin
      if (pending_cmds.size() == 0) begin
        report("result with nothing expected", 1, 0);
      end else begin
        want = pending_cmds.pop_front();
        if (gait_mode_o !== want.mode) report("gait_mode", gait_mode_o, want.mode);
        if (target_speed_o !== want.speed) report("target_speed", target_speed_o, want.speed);
        if (move_x_o !== want.mx) report("move_x", move_x_o, want.mx);
        if (move_y_o !== want.my) report("move_y", move_y_o, want.my);
        if (face_x_o !== want.fx) report("face_x", face_x_o, want.fx);
        if (face_y_o !== want.fy) report("face_y", face_y_o, want.fy);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    command_t c;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      c.fwd = 16'(rows[i].fwd);
      c.lat = 16'(rows[i].lat);
      c.turn = 16'(rows[i].turn);
      c.qw = 16'(rows[i].qw);
      c.qx = 16'(rows[i].qx);
      c.qy = 16'(rows[i].qy);
      c.qz = 16'(rows[i].qz);
      c.empty = (rows[i].empty != 0);
      c.href = 15'(rows[i].href);
      c.yplan = 15'(rows[i].yplan);
      issue(c, rows[i].typed, rows[i].mode, rows[i].speed);
    end

    // Random phases; all but the first write new register settings first.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        1: begin
          write_reg(RegIdleLimit, 16'd0);
          write_reg(RegWalkLimit, 16'd0);
          write_reg(RegFaceLead, 16'd0);
        end
        2: begin
          write_reg(RegIdleLimit, 16'hffff);
          write_reg(RegWalkLimit, 16'hffff);
          write_reg(RegFaceLead, 16'h3fff);
        end
        3: begin
          write_reg(RegIdleLimit, 16'd2000);
          write_reg(RegWalkLimit, 16'd8000);
          write_reg(RegFaceLead, 16'hffff);
        end
        4: begin
          // An unknown register index must leave the setting alone.
          write_reg(2'd3, 16'h1234);
          write_reg(RegIdleLimit, 16'd100);
          write_reg(RegWalkLimit, 16'd40000);
        end
        5: begin
          write_reg(RegIdleLimit, 16'd492);
          write_reg(RegWalkLimit, 16'd3277);
          write_reg(RegFaceLead, 16'd2458);
        end
        default: ;
      endcase
      for (int n = 0; n < 280; n++) issue(random_command(), 0, ModeIdle, 0);
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_cmds.size() != 0) begin
      report("results never arrived", pending_cmds.size(), 0);
    end
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
